>>> rtl/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg
// Shared types and constants for the sequence gap tracker.
// ----------------------------------------------------------------------------
package sgt_pkg;

    localparam int SeqWidth   = 64;
    localparam int CountWidth = 64;

    localparam logic [31:0] SPACE32_HALF = 32'h8000_0000;

    // result classification
    typedef enum logic [2:0] {
        KIND_FIRST = 3'd0,
        KIND_NEXT  = 3'd1,
        KIND_GAP   = 3'd2,
        KIND_DUP   = 3'd3,
        KIND_WRAP  = 3'd4,
        KIND_OOO   = 3'd5,
        KIND_CLEAR = 3'd6
    } kind_t;

    // input operation codes
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // tracker history handed to the classifier
    typedef struct packed {
        logic                have_prev;
        logic [SeqWidth-1:0] prev;
    } track_t;

    // classifier decision handed back to the core
    typedef struct packed {
        kind_t                 kind;
        logic [CountWidth-1:0] missed;
        logic                  clear;
        logic                  move_prev;
        logic                  inc_dup;
        logic                  inc_ooo;
        logic                  inc_wrap;
    } step_t;

endpackage

>>> rtl/sgt_classify.sv
// ----------------------------------------------------------------------------
// sgt_classify
// Classifies one sequence number against the tracker history.
// ----------------------------------------------------------------------------
module sgt_classify
(
    input  logic                         operation,
    input  logic [sgt_pkg::SeqWidth-1:0] sequence_value,
    input  logic                         narrow_mode,
    input  sgt_pkg::track_t              track,
    output sgt_pkg::step_t               step
);

    logic [sgt_pkg::SeqWidth-1:0] diff_m1;
    logic [sgt_pkg::SeqWidth-1:0] back;
    logic                         is_fwd;
    logic                         is_eq;
    logic                         wrap_ok;

    // seq - prev - 1; its complement is prev - seq
    assign diff_m1 = sequence_value + ~track.prev;
    assign back    = ~diff_m1;
    assign is_fwd  = sequence_value > track.prev;
    assign is_eq   = sequence_value == track.prev;

    // both values in 32-bit space and a backward jump over half of it
    assign wrap_ok = narrow_mode
                     && (track.prev[63:32] == 32'd0)
                     && (sequence_value[63:32] == 32'd0)
                     && (back[31:0] > sgt_pkg::SPACE32_HALF);

    always_comb
    begin
        step           = '0;
        step.kind      = sgt_pkg::KIND_FIRST;
        if (operation == sgt_pkg::OP_CLEAR)
        begin
            step.kind  = sgt_pkg::KIND_CLEAR;
            step.clear = 1'b1;
        end
        else if (!track.have_prev)
        begin
            step.kind      = sgt_pkg::KIND_FIRST;
            step.move_prev = 1'b1;
        end
        else if (is_eq)
        begin
            step.kind    = sgt_pkg::KIND_DUP;
            step.inc_dup = 1'b1;
        end
        else if (is_fwd)
        begin
            step.move_prev = 1'b1;
            if (diff_m1 != '0)
            begin
                step.kind   = sgt_pkg::KIND_GAP;
                step.missed = diff_m1;
            end
            else
            begin
                step.kind = sgt_pkg::KIND_NEXT;
            end
        end
        else if (wrap_ok)
        begin
            // forward distance mod 2^32 minus one fits in the low word
            step.kind      = sgt_pkg::KIND_WRAP;
            step.missed    = {32'd0, diff_m1[31:0]};
            step.move_prev = 1'b1;
            step.inc_wrap  = 1'b1;
        end
        else
        begin
            step.kind    = sgt_pkg::KIND_OOO;
            step.inc_ooo = 1'b1;
        end
    end

endmodule

>>> rtl/sequence_gap_tracker_core.sv
// ----------------------------------------------------------------------------
// sequence_gap_tracker_core
// Sequence number gap, duplicate, reorder and wrap tracker, stream interface.
// ----------------------------------------------------------------------------
// Takes one sequence number (or clear) per clock, sustained while m_tready
// stays high. From input transfer to result: an input register, then one
// classify stage that updates the tracker history and counters and loads the
// result register. The critical path is the loop on the tracker state in
// the classify stage: a 64-bit compare/subtract followed by the 64-bit drop
// accumulate. A stalled result holds the next item in the input register
// and then drops s_tready. narrow_mode is written through cfg_we/cfg_wdata
// by the user only while the block is idle; the block does not enforce it.
module sequence_gap_tracker_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_wdata,   // [0] narrow_mode
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,     // [63:0] sequence_value
    input  logic [0:0]   s_tuser,     // [0] operation
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] missed_now, [127:64] total_seen, [191:128] total_dropped,
    // [255:192] total_duplicate, [319:256] total_reordered,
    // [383:320] total_wrapped
    output logic [383:0] m_tdata,
    output logic [2:0]   m_tuser      // [2:0] event_kind
);

    localparam int CW = sgt_pkg::CountWidth;
    localparam int SW = sgt_pkg::SeqWidth;

    logic          narrow_reg;
    logic          in_valid_reg;
    logic          in_op_reg;
    logic [SW-1:0] in_seq_reg;

    logic          have_prev_reg, have_prev_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic [CW-1:0] drop_reg, drop_next;
    logic [CW-1:0] dup_reg, dup_next;
    logic [CW-1:0] ooo_reg, ooo_next;
    logic [CW-1:0] wrap_reg, wrap_next;

    logic          out_valid_reg, out_valid_next;
    logic [383:0]  out_data_reg;
    logic [2:0]    out_user_reg;

    logic            advance;
    logic            in_take;
    sgt_pkg::track_t track;
    sgt_pkg::step_t  step;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign track.have_prev = have_prev_reg;
    assign track.prev      = prev_reg;

    sgt_classify u_classify
    (
        .operation      (in_op_reg),
        .sequence_value (in_seq_reg),
        .narrow_mode    (narrow_reg),
        .track          (track),
        .step           (step)
    );

    always_comb
    begin
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        seen_next      = seen_reg;
        drop_next      = drop_reg;
        dup_next       = dup_reg;
        ooo_next       = ooo_reg;
        wrap_next      = wrap_reg;
        if (step.clear)
        begin
            have_prev_next = 1'b0;
            prev_next      = '0;
            seen_next      = '0;
            drop_next      = '0;
            dup_next       = '0;
            ooo_next       = '0;
            wrap_next      = '0;
        end
        else
        begin
            have_prev_next = 1'b1;
            if (step.move_prev)
            begin
                prev_next = in_seq_reg;
            end
            seen_next = seen_reg + CW'(1);
            drop_next = drop_reg + step.missed;
            dup_next  = dup_reg + CW'(step.inc_dup);
            ooo_next  = ooo_reg + CW'(step.inc_ooo);
            wrap_next = wrap_reg + CW'(step.inc_wrap);
        end
    end

    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            seen_reg      <= '0;
            drop_reg      <= '0;
            dup_reg       <= '0;
            ooo_reg       <= '0;
            wrap_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                narrow_reg <= cfg_wdata[0];
            end
            in_valid_reg  <= in_take || (in_valid_reg && !advance);
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                have_prev_reg <= have_prev_next;
                prev_reg      <= prev_next;
                seen_reg      <= seen_next;
                drop_reg      <= drop_next;
                dup_reg       <= dup_next;
                ooo_reg       <= ooo_next;
                wrap_reg      <= wrap_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg  <= s_tuser[0];
            in_seq_reg <= s_tdata;
        end
        if (advance)
        begin
            out_user_reg <= step.kind;
            out_data_reg <= {wrap_next, ooo_next, dup_next, drop_next, seen_next,
                             step.missed};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> rtl/sgt_checker.sv
// ----------------------------------------------------------------------------
// sgt_checker
// Port-level checks on the tracker results, bound to the top level.
// ----------------------------------------------------------------------------
module sgt_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [383:0] m_tdata,
    input logic [2:0]   m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // with the result side empty the input side is open
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with no result pending");

    // clear reports all totals zero
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == sgt_pkg::KIND_CLEAR) |-> (m_tdata == '0))
        else $error("clear result not zero");

    // first observation since clear: one seen, nothing else counted
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == sgt_pkg::KIND_FIRST)
        |-> (m_tdata[127:64] == 64'd1) && (m_tdata[63:0] == 64'd0)
            && (m_tdata[383:128] == '0))
        else $error("first result counters wrong");

    // only gaps and wraps report drops
    a_no_missed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == sgt_pkg::KIND_NEXT) || (m_tuser == sgt_pkg::KIND_DUP)
                     || (m_tuser == sgt_pkg::KIND_OOO))
        |-> (m_tdata[63:0] == 64'd0))
        else $error("missed count on non-drop event");

endmodule

bind sequence_gap_tracker_core sgt_checker u_sgt_checker (.*);

>>> bench/sgt_stream_checker.sv
// ----------------------------------------------------------------------------
// sgt_stream_checker
// Watches the config port and both stream channels of the sequence gap
// tracker. Computes the expected classification and totals for every input
// transfer and compares them, field by field, with each result transfer.
// ----------------------------------------------------------------------------
module sgt_stream_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [383:0] m_tdata,
    input  logic [2:0]   m_tuser,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SPACE32_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct {
        sgt_pkg::kind_t kind;
        logic [63:0]    missed;
        logic [63:0]    seen;
        logic [63:0]    dropped;
        logic [63:0]    dups;
        logic [63:0]    reordered;
        logic [63:0]    wraps;
    } tracker_result_t;

    logic        narrow_mode;
    logic        have_prev;
    logic [63:0] prev_seq;
    logic [63:0] seen_cnt;
    logic [63:0] dropped_cnt;
    logic [63:0] dup_cnt;
    logic [63:0] reorder_cnt;
    logic [63:0] wrap_cnt;

    tracker_result_t expected_events[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void clear_tracker();
        have_prev   = 1'b0;
        prev_seq    = '0;
        seen_cnt    = '0;
        dropped_cnt = '0;
        dup_cnt     = '0;
        reorder_cnt = '0;
        wrap_cnt    = '0;
    endfunction

    function automatic tracker_result_t classify_sequence(logic op, logic [63:0] seq);
        tracker_result_t r;
        logic [63:0]     adv;
        r.missed = '0;
        if (op == sgt_pkg::OP_CLEAR)
        begin
            clear_tracker();
            r.kind = sgt_pkg::KIND_CLEAR;
        end
        else
        begin
            seen_cnt++;
            if (!have_prev)
            begin
                have_prev = 1'b1;
                prev_seq  = seq;
                r.kind    = sgt_pkg::KIND_FIRST;
            end
            else if (seq == prev_seq)
            begin
                dup_cnt++;
                r.kind = sgt_pkg::KIND_DUP;
            end
            else if (seq > prev_seq)
            begin
                adv = seq - prev_seq;
                if (adv > 64'd1)
                begin
                    r.missed = adv - 64'd1;
                    r.kind   = sgt_pkg::KIND_GAP;
                end
                else
                    r.kind = sgt_pkg::KIND_NEXT;
                dropped_cnt += r.missed;
                prev_seq     = seq;
            end
            // wrap only when both numbers live in the 32-bit space and the
            // backward step is more than half of it
            else if (narrow_mode && prev_seq <= SPACE32_MAX && seq <= SPACE32_MAX &&
                     (prev_seq - seq) > {32'b0, sgt_pkg::SPACE32_HALF})
            begin
                adv = (SPACE32_MAX - prev_seq) + 64'd1 + seq;
                if (adv > 64'd1)
                    r.missed = adv - 64'd1;
                dropped_cnt += r.missed;
                wrap_cnt++;
                prev_seq = seq;
                r.kind   = sgt_pkg::KIND_WRAP;
            end
            else
            begin
                reorder_cnt++;
                r.kind = sgt_pkg::KIND_OOO;
            end
        end
        r.seen      = seen_cnt;
        r.dropped   = dropped_cnt;
        r.dups      = dup_cnt;
        r.reordered = reorder_cnt;
        r.wraps     = wrap_cnt;
        return r;
    endfunction

    task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tracker_result_t want;
        if (!rst_n)
        begin
            narrow_mode = 1'b0;
            clear_tracker();
            expected_events.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                narrow_mode = cfg_wdata[0];
            if (s_tvalid && s_tready)
            begin
                want = classify_sequence(s_tuser[0], s_tdata);
                expected_events.insert(expected_events.size(), want);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t ns: unexpected result transfer, kind %0d",
                             $time, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", {61'b0, want.kind}, {61'b0, m_tuser});
                    check_field("missed_now",      want.missed,    m_tdata[63:0]);
                    check_field("total_seen",      want.seen,      m_tdata[127:64]);
                    check_field("total_dropped",   want.dropped,   m_tdata[191:128]);
                    check_field("total_duplicate", want.dups,      m_tdata[255:192]);
                    check_field("total_reordered", want.reordered, m_tdata[319:256]);
                    check_field("total_wrapped",   want.wraps,     m_tdata[383:320]);
                end
            end
            pending = expected_events.size();
        end
    end

endmodule

>>> bench/sequence_gap_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// sequence_gap_tracker_core_tb
// Drives sequence numbers and clears into the tracker in both sequence
// spaces: a directed pass over gaps, duplicates, reorders and wraps, then
// random runs of mostly well-formed sequences with bursty input and a
// stalling result side. Checking is done by sgt_stream_checker.
// ----------------------------------------------------------------------------
module sequence_gap_tracker_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RAND_PHASES      = 7;
    localparam int          ITEMS_PER_PHASE  = 220;
    localparam logic [6:0]  PHASE_NARROW     = 7'b0101101;
    localparam logic [63:0] ALL_ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_we;
    logic [0:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [383:0] m_tdata;
    logic [2:0]   m_tuser;
    int           fail_count;
    int           pending;

    int           burst_left  = 0;
    bit           idle_on     = 1'b1;
    int           rx_mode     = 0;
    int           rx_mode_left = 0;
    int           hold_left   = 0;
    bit           hold_ready  = 1'b0;

    sequence_gap_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sgt_stream_checker tracker_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: stall style is chosen at random from four modes
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(100, 400);
        end
        rx_mode_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ~m_tready;
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_ready = ~hold_ready;
                    hold_left  = hold_ready ? $urandom_range(1, 8) : $urandom_range(5, 20);
                end
                hold_left--;
                m_tready <= hold_ready;
            end
        endcase
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(logic op, logic [63:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (idle_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic observe(logic [63:0] value);
        send_item(sgt_pkg::OP_OBSERVE, value);
    endtask

    task automatic clear_history();
        send_item(sgt_pkg::OP_CLEAR, {$urandom, $urandom});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_mode(logic mode);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int          pick;
        logic [63:0] value;
        logic [63:0] cursor;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = sgt_pkg::OP_OBSERVE;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 64-bit space
        write_mode(1'b0);
        observe(64'd5);
        observe(64'd6);
        observe(64'd10);
        observe(64'd10);
        observe(64'd7);
        observe(ALL_ONES);
        observe(64'd0);
        clear_history();
        observe(64'd0);
        observe(ALL_ONES);
        clear_history();
        observe(64'h0000_0000_FFFF_FFFF);
        observe(64'd0);             // no wrap outside narrow mode
        drain();

        // 32-bit space with wrap detection
        write_mode(1'b1);
        clear_history();
        observe(64'h0000_0000_FFFF_FFFF);
        observe(64'd0);             // wrap by one
        observe(64'd5);
        observe(64'h0000_0000_9000_0000);
        observe(64'd3);             // wrap with drops
        observe(64'h0000_0000_8000_0003);
        observe(64'd3);             // exactly half back: reorder
        observe(64'h0000_0001_0000_0005);
        observe(64'd2);             // last number wide: reorder
        observe(64'd2);
        drain();

        cursor = '0;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            write_mode(PHASE_NARROW[phase]);
            idle_on = (phase != 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    clear_history();
                else
                begin
                    if (pick < 45)
                        value = cursor + 64'd1;
                    else if (pick < 60)
                        value = cursor + 64'($urandom_range(2, 40));
                    else if (pick < 68)
                        value = cursor;
                    else if (pick < 76)
                        value = cursor - 64'($urandom_range(1, 40));
                    else if (pick < 84)
                        value = {32'b0, $urandom};
                    else if (pick < 89)
                        value = 64'($urandom_range(0, 20));
                    else if (pick < 94)
                        value = 64'h0000_0000_FFFF_FFFF - 64'($urandom_range(0, 20));
                    else if (pick < 97)
                        value = {$urandom, $urandom};
                    else
                        value = ALL_ONES - 64'($urandom_range(0, 20));
                    observe(value);
                    cursor = value;
                end
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/sgt_pkg.sv
rtl/sgt_classify.sv
rtl/sequence_gap_tracker_core.sv
rtl/sgt_checker.sv
bench/sgt_stream_checker.sv
bench/sequence_gap_tracker_core_tb.sv
